// ----- src/bsp_pkg.sv -----
package bsp_pkg;

  // Store geometry
  localparam int STORE_BYTES    = 512;
  localparam int MAX_CHUNK_BITS = 32;
  localparam int CAP_BITS       = STORE_BYTES * 8;

  // Field widths of one transaction
  localparam int KIND_W  = 2;
  localparam int COUNT_W = 6;
  localparam int DATA_W  = 32;
  localparam int TOTAL_W = 13;

  localparam int IN_FIELDS_W  = COUNT_W + DATA_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = TOTAL_W + DATA_W + COUNT_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Largest count a transaction may carry
  localparam int CHUNK_LIMIT = (MAX_CHUNK_BITS < DATA_W) ? MAX_CHUNK_BITS : DATA_W;

  // Bit length and pointer width
  localparam int LEN_W  = $clog2(CAP_BITS + 1);
  localparam int LEN1_W = LEN_W + 1;

  // The store is kept as 32-bit words split over an even and an odd bank,
  // so any chunk touches one word of each bank.
  localparam int WORD_W     = 32;
  localparam int PAIR_W     = 2 * WORD_W;
  localparam int OFF_W      = $clog2(WORD_W);
  localparam int BANK_DEPTH = (STORE_BYTES * 8) / PAIR_W;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int WIDX_W     = BANK_AW + 1;

  // Transaction kinds
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;  // latch the input transaction and issue the bank reads
    logic commit;  // write back, update pointers and load the result
  } cmd_t;

endpackage

// ----- src/bsp_ram.sv -----
module bsp_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/bsp_ctrl.sv -----
module bsp_ctrl import bsp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  // Result register can take a new value when empty or draining
  assign out_free = !out_valid_q || out_ready_i;

  // Sequence one transaction: read in IDLE, write back in EXEC
  always_comb begin
    state_d       = state_q;
    cmd_o.accept  = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold the result valid until the downstream takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- src/bsp_dpath.sv -----
module bsp_dpath import bsp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  input  logic [IN_TDATA_W-1:0]  in_tdata_i,
  input  logic [KIND_W-1:0]      in_tuser_i,
  output logic [OUT_TDATA_W-1:0] out_tdata_o
);

  // Input fields
  logic [COUNT_W-1:0] count_in;
  logic [COUNT_W-1:0] count_sat;
  logic [DATA_W-1:0]  chunk_in;
  logic [LEN_W-1:0]   pos;
  logic [WIDX_W-1:0]  widx;
  logic [WIDX_W-1:0]  widx_inc;

  // Latched transaction
  logic [KIND_W-1:0]  kind_q;
  logic [COUNT_W-1:0] cnt_q;
  logic [DATA_W-1:0]  chunk_q;
  logic [OFF_W-1:0]   off_q;
  logic               par_q;
  logic [BANK_AW-1:0] even_addr_q;
  logic [BANK_AW-1:0] odd_addr_q;

  // Stream pointers
  logic [LEN_W-1:0] wl_q, wl_d;
  logic [LEN_W-1:0] rp_q, rp_d;

  // Bank data and merge
  logic [WORD_W-1:0]  even_rd, odd_rd;
  logic [WORD_W-1:0]  even_wd, odd_wd;
  logic [PAIR_W-1:0]  pair, ins_mask, ins_data, merged, rd_mask;
  logic               fits;
  logic               wr_en;
  logic [LEN_W-1:0]   avail;
  logic [COUNT_W-1:0] rd_cnt;
  logic [DATA_W-1:0]  rd_data;

  // Result fields
  logic [DATA_W-1:0]      res_data;
  logic [COUNT_W-1:0]     res_cnt;
  logic                   res_ovf;
  logic [OUT_TDATA_W-1:0] out_d;
  logic [OUT_TDATA_W-1:0] out_q;

  // Unpack and saturate the incoming count
  assign count_in  = in_tdata_i[COUNT_W-1:0];
  assign chunk_in  = in_tdata_i[COUNT_W+DATA_W-1:COUNT_W];
  assign count_sat = (count_in > COUNT_W'(CHUNK_LIMIT)) ? COUNT_W'(CHUNK_LIMIT) : count_in;

  // Word addresses around the active pointer
  assign pos      = (in_tuser_i == KIND_READ) ? rp_q : wl_q;
  assign widx     = pos[BANK_AW+OFF_W:OFF_W];
  assign widx_inc = widx + WIDX_W'(1);

  // Latch the transaction on accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q      <= in_tuser_i;
      cnt_q       <= count_sat;
      chunk_q     <= chunk_in;
      off_q       <= pos[OFF_W-1:0];
      par_q       <= widx[0];
      even_addr_q <= widx_inc[BANK_AW:1];
      odd_addr_q  <= widx[BANK_AW:1];
    end
  end

  // Order the two bank words as low and high halves of the window
  assign pair = par_q ? {even_rd, odd_rd} : {odd_rd, even_rd};

  // Insert the chunk at the bit offset
  assign ins_mask = ((PAIR_W'(1) << cnt_q) - PAIR_W'(1)) << off_q;
  assign ins_data = PAIR_W'(chunk_q) << off_q;
  assign merged   = (pair & ~ins_mask) | (ins_data & ins_mask);
  assign even_wd  = par_q ? merged[PAIR_W-1:WORD_W] : merged[WORD_W-1:0];
  assign odd_wd   = par_q ? merged[WORD_W-1:0] : merged[PAIR_W-1:WORD_W];

  // Room check and read extraction
  assign fits    = ({1'b0, wl_q} + LEN1_W'(cnt_q)) <= LEN1_W'(CAP_BITS);
  assign avail   = wl_q - rp_q;
  assign rd_cnt  = (LEN_W'(cnt_q) < avail) ? cnt_q : COUNT_W'(avail);
  assign rd_mask = (PAIR_W'(1) << rd_cnt) - PAIR_W'(1);
  assign rd_data = DATA_W'((pair >> off_q) & rd_mask);

  // Decode the operation
  always_comb begin
    wl_d     = wl_q;
    rp_d     = rp_q;
    wr_en    = 1'b0;
    res_data = '0;
    res_cnt  = '0;
    res_ovf  = 1'b0;
    case (kind_q)
      KIND_APPEND: begin
        if (fits) begin
          wl_d  = wl_q + LEN_W'(cnt_q);
          wr_en = (cnt_q != '0);
        end else begin
          res_ovf = 1'b1;
        end
      end
      KIND_READ: begin
        rp_d     = rp_q + LEN_W'(rd_cnt);
        res_data = rd_data;
        res_cnt  = rd_cnt;
      end
      KIND_CLEAR: begin
        wl_d = '0;
        rp_d = '0;
      end
      default: begin
        wl_d = wl_q;
      end
    endcase
  end

  // Advance the pointers on commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= '0;
      rp_q <= '0;
    end else if (cmd_i.commit) begin
      wl_q <= wl_d;
      rp_q <= rp_d;
    end
  end

  // Pack and hold the result
  always_comb begin
    out_d = '0;
    out_d[TOTAL_W-1:0]                                = TOTAL_W'(wl_d);
    out_d[TOTAL_W+DATA_W-1:TOTAL_W]                   = res_data;
    out_d[TOTAL_W+DATA_W+COUNT_W-1:TOTAL_W+DATA_W]    = res_cnt;
    out_d[TOTAL_W+DATA_W+COUNT_W]                     = res_ovf;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  assign out_tdata_o = out_q;

  // Even-word bank
  bsp_ram #(
    .Width (WORD_W),
    .Depth (BANK_DEPTH)
  ) u_even_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && wr_en),
    .waddr_i (even_addr_q),
    .wdata_i (even_wd),
    .re_i    (cmd_i.accept),
    .raddr_i (widx_inc[BANK_AW:1]),
    .rdata_o (even_rd)
  );

  // Odd-word bank
  bsp_ram #(
    .Width (WORD_W),
    .Depth (BANK_DEPTH)
  ) u_odd_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && wr_en),
    .waddr_i (odd_addr_q),
    .wdata_i (odd_wd),
    .re_i    (cmd_i.accept),
    .raddr_i (widx[BANK_AW:1]),
    .rdata_o (odd_rd)
  );

endmodule

// ----- src/bit_stream_pack_unpack_top.sv -----
// Each accepted input transaction is latched and its two bank words are read; the write-back
// to the two-bank word store (read-modify-write) and the result load follow once the output
// register is free. A new transaction is not taken until the previous one is written back.
// A finished result waits in an output register while the next transaction is taken.
// Reset clears the bit length, read pointer and handshake state; store contents stay
// undefined until written, and no clearing pass runs.
module bit_stream_pack_unpack_top import bsp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // bit_count, chunk_data, zero pad
  input  logic [KIND_W-1:0]      s_axis_tuser_i,   // kind
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o    // total_bits, read_data, bits_read,
                                                   // overflow, zero pad
);

  cmd_t cmd;

  // Transaction sequencing and result handshake
  bsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  // Store, pointers and bit alignment
  bsp_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_tdata_i  (s_axis_tdata_i),
    .in_tuser_i  (s_axis_tuser_i),
    .out_tdata_o (m_axis_tdata_o)
  );

endmodule

// ----- bench/bit_stream_pack_unpack_top_tb.sv -----
module bit_stream_pack_unpack_top_tb;
  import bsp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Kind code that the block treats as no operation
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1150;
  localparam int MAX_REPORTS  = 10;
  localparam int LONG_HOLD    = 250;

  typedef struct packed {
    logic               drain_first;  // wait for all results before offering
    logic [KIND_W-1:0]  kind;
    logic [COUNT_W-1:0] bit_count;
    logic [DATA_W-1:0]  chunk_data;
  } stream_item_t;

  // Lowest field last, so the struct maps straight onto tdata
  typedef struct packed {
    logic               overflow;
    logic [COUNT_W-1:0] bits_read;
    logic [DATA_W-1:0]  read_data;
    logic [TOTAL_W-1:0] total_bits;
  } stream_result_t;

  logic                   clk_i;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;   // bit_count, chunk_data, zero pad
  logic [KIND_W-1:0]      s_axis_tuser_i  = '0;   // kind
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;         // total_bits, read_data, bits_read,
                                                  // overflow, zero pad

  bit_stream_pack_unpack_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Pending stimulus and expected results
  stream_item_t   pending_items[$];
  stream_result_t expected_results[$];
  stream_item_t   cur_item = '0;
  int             total_items;
  int             items_accepted = 0;
  int             results_seen   = 0;
  int             send_wait      = 0;
  int             recv_wait      = 0;
  logic           long_hold      = 1'b0;
  int             error_count    = 0;

  // Predicted store state
  logic [CAP_BITS-1:0] model_bits = '0;
  int                  model_length;
  int                  model_rdpos;

  // Run statistics
  int n_append, n_reject, n_read, n_short_read, n_clear, n_unused;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one transaction to the predicted store and return its result
  function automatic stream_result_t predict_stream_result(stream_item_t it);
    stream_result_t r;
    int n;
    int avail;
    r = '0;
    n = (it.bit_count > CHUNK_LIMIT) ? CHUNK_LIMIT : int'(it.bit_count);
    case (it.kind)
      KIND_APPEND: begin
        n_append++;
        if (model_length + n > CAP_BITS) begin
          r.overflow = 1'b1;
          n_reject++;
        end else begin
          for (int i = 0; i < n; i++) model_bits[model_length + i] = it.chunk_data[i];
          model_length += n;
        end
      end
      KIND_READ: begin
        n_read++;
        avail = (model_length > model_rdpos) ? model_length - model_rdpos : 0;
        if (avail < n) begin
          n = avail;
          n_short_read++;
        end
        for (int i = 0; i < n; i++) r.read_data[i] = model_bits[model_rdpos + i];
        r.bits_read = COUNT_W'(n);
        model_rdpos += n;
      end
      KIND_CLEAR: begin
        n_clear++;
        model_length = 0;
        model_rdpos  = 0;
      end
      default: n_unused++;
    endcase
    r.total_bits = TOTAL_W'(model_length);
    return r;
  endfunction

  task automatic add_item(logic [KIND_W-1:0] kind, int count, logic [DATA_W-1:0] data,
                          bit drain = 1'b0);
    stream_item_t it;
    it.drain_first = drain;
    it.kind        = kind;
    it.bit_count   = COUNT_W'(count);
    it.chunk_data  = data;
    pending_items.push_back(it);
  endtask

  function automatic int draw_count();
    return ($urandom_range(0, 99) < 85) ? int'($urandom_range(0, 32))
                                        : int'($urandom_range(33, 63));
  endfunction

  // Sender: offer queued transactions, hold on stall, idle between them
  always @(posedge clk_i or negedge rst_ni) begin : sender
    stream_item_t nxt;
    logic         took;
    logic         drained;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= '0;
      send_wait       <= 0;
      items_accepted  <= 0;
    end else begin
      took = s_axis_tvalid_i && s_axis_tready_o;
      if (took) begin
        expected_results.push_back(predict_stream_result(cur_item));
        items_accepted <= items_accepted + 1;
      end
      drained = (results_seen == items_accepted + took);
      if (s_axis_tvalid_i && !took) begin
        // hold the current transaction
      end else if (send_wait > 0) begin
        s_axis_tvalid_i <= 1'b0;
        send_wait       <= send_wait - 1;
      end else if (pending_items.size() != 0 && (!pending_items[0].drain_first || drained)) begin
        nxt = pending_items.pop_front();
        cur_item        <= nxt;
        s_axis_tdata_i  <= IN_TDATA_W'({nxt.chunk_data, nxt.bit_count});
        s_axis_tuser_i  <= nxt.kind;
        s_axis_tvalid_i <= 1'b1;
        send_wait       <= (items_accepted % 128 < 40) ? 0 : int'($urandom_range(0, 13));
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver: check each result against the oldest prediction, stall at random
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    stream_result_t got;
    stream_result_t exp_r;
    logic           took;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      recv_wait       <= 0;
      results_seen    <= 0;
    end else begin
      took = m_axis_tvalid_o && m_axis_tready_i;
      if (took) begin
        got = stream_result_t'(m_axis_tdata_o[OUT_FIELDS_W-1:0]);
        results_seen <= results_seen + 1;
        if (results_seen >= items_accepted) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("[%0t] unexpected result: total=%0d data=%h count=%0d ovf=%b", $realtime,
                     got.total_bits, got.read_data, got.bits_read, got.overflow);
        end else begin
          exp_r = expected_results.pop_front();
          if (got.total_bits !== exp_r.total_bits || got.read_data !== exp_r.read_data ||
              got.bits_read !== exp_r.bits_read || got.overflow !== exp_r.overflow) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("[%0t] result %0d mismatch: expected total %0d data %h count %0d ovf %b",
                       $realtime, results_seen, exp_r.total_bits, exp_r.read_data,
                       exp_r.bits_read, exp_r.overflow);
              $display("    actual total %0d data %h count %0d ovf %b",
                       got.total_bits, got.read_data, got.bits_read, got.overflow);
            end
          end
        end
      end
      // Drop ready for a long hold, or for a drawn stall after a result outside the always-ready runs
      if (long_hold) begin
        m_axis_tready_i <= 1'b0;
      end else if (took) begin
        if (results_seen % 96 < 30) begin
          m_axis_tready_i <= 1'b1;
          recv_wait       <= 0;
        end else begin
          recv_wait       <= int'($urandom_range(0, 13));
          m_axis_tready_i <= 1'b0;
        end
      end else if (recv_wait > 0) begin
        m_axis_tready_i <= 1'b0;
        recv_wait       <= recv_wait - 1;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Back-pressure: block the output long enough for the input to stall
  initial begin
    while (items_accepted < 400) @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int added;
    int run_len;
    int bias;
    int roll;
    model_length = 0;
    model_rdpos  = 0;
    {n_append, n_reject, n_read, n_short_read, n_clear, n_unused} = '0;

    // Directed: empty reads, saturated counts, zero counts, unused kind, clear
    add_item(KIND_READ,    5, $urandom());
    add_item(KIND_APPEND,  0, 32'hFFFF_FFFF);
    add_item(KIND_APPEND, 32, 32'hFFFF_FFFF);
    add_item(KIND_APPEND, 63, 32'h0000_0000);
    add_item(KIND_APPEND,  1, 32'hFFFF_FFFF);
    add_item(KIND_APPEND,  7, 32'h5555_5555);
    add_item(KIND_READ,    0, $urandom());
    add_item(KIND_READ,    1, $urandom());
    add_item(KIND_READ,   32, $urandom());
    add_item(KIND_READ,   63, $urandom());
    add_item(KIND_READ,   32, $urandom());
    add_item(KIND_READ,   10, $urandom());
    add_item(KIND_UNUSED, 17, 32'hDEAD_BEEF);
    add_item(KIND_APPEND, 33, 32'hA5A5_A5A5);
    add_item(KIND_CLEAR,  63, 32'hFFFF_FFFF);
    add_item(KIND_READ,    8, $urandom());
    add_item(KIND_APPEND, 31, 32'h7FFF_FFFF);
    add_item(KIND_APPEND, 17, 32'h0001_2345);
    add_item(KIND_READ,   48, $urandom());
    add_item(KIND_UNUSED,  0, 32'h0000_0000);
    add_item(KIND_READ,   32, $urandom());
    add_item(KIND_CLEAR,   0, 32'h0000_0000);

    // Fill the store to capacity, then push past it
    added = 0;
    for (int i = 0; i < CAP_BITS / 32; i++) begin
      add_item(KIND_APPEND, 32, $urandom(), i == 0);
      added++;
    end
    add_item(KIND_APPEND,  1, $urandom());
    add_item(KIND_APPEND,  0, $urandom());
    add_item(KIND_APPEND, 32, $urandom());
    for (int i = 0; i < 4; i++) add_item(KIND_READ, 32, $urandom());
    add_item(KIND_APPEND, 63, $urandom());
    add_item(KIND_CLEAR, $urandom_range(0, 63), $urandom());
    added += 9;

    // Random runs, each biased toward appends, reads or an even mix
    while (added < RANDOM_ITEMS) begin
      run_len = $urandom_range(20, 120);
      bias    = (bias == 0) ? 75 : 30 + 20 * int'($urandom_range(0, 2));
      for (int i = 0; i < run_len; i++) begin
        roll = $urandom_range(0, 199);
        if (roll < 1)
          add_item(KIND_CLEAR, draw_count(), $urandom(), i == 0 && $urandom_range(0, 9) == 0);
        else if (roll < 3)
          add_item(KIND_UNUSED, draw_count(), $urandom(), i == 0 && $urandom_range(0, 9) == 0);
        else if (roll < 2 * bias)
          add_item(KIND_APPEND, draw_count(), $urandom(), i == 0 && $urandom_range(0, 9) == 0);
        else
          add_item(KIND_READ, draw_count(), $urandom(), i == 0 && $urandom_range(0, 9) == 0);
      end
      added += run_len;
      if ($urandom_range(0, 99) < 30) begin
        add_item(KIND_CLEAR, draw_count(), $urandom());
        added++;
      end
    end
    total_items = pending_items.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(items_accepted == total_items && results_seen == items_accepted))
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (expected_results.size() != 0) error_count++;

    $display("Ran %0d transactions: %0d appends (%0d rejected for room), %0d reads",
             items_accepted, n_append, n_reject, n_read);
    $display("(%0d cut at end of data), %0d clears, %0d unused kinds; %0d errors",
             n_short_read, n_clear, n_unused, error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/bsp_pkg.sv
src/bsp_ram.sv
src/bsp_ctrl.sv
src/bsp_dpath.sv
src/bit_stream_pack_unpack_top.sv
bench/bit_stream_pack_unpack_top_tb.sv
